[design/rmst_pkg.sv]
// Package for the 2D range-maximum sparse table: request codes, sizes and helpers.
// No dependencies.
package rmst_pkg;

  localparam int MaxDim = 32;
  localparam int Levels = 6;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  // Position of the highest set bit of a 6-bit length, clamped to the top level.
  function automatic logic [2:0] flog2(input logic [5:0] v);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (v[i]) k = 3'(i);
    end
    if (int'(k) > Levels - 1) k = 3'(Levels - 1);
    return k;
  endfunction

endpackage

[design/range_max_sparse_table_2d.sv]
// Two-dimensional sparse table for rectangle maximum queries.
// Write: the cell is written in the cycle of its transfer. Query: four table reads on one
// port, then a wait state; the result is held until taken and no request is taken before.
// Bad query: no table reads, straight to the result. Build: each table position visited
// passes a check and a step state, each entry written also a read, a second read above
// level 0, and a write. After reset a clearing pass zeroes the 1024-word grid memory; no
// item is taken then. Reset is synchronous, active low; config registers reset to 32.
module range_max_sparse_table_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_row_start,
  input  logic [4:0]  in_col_start,
  input  logic [4:0]  in_row_end,
  input  logic [4:0]  in_col_end,
  input  logic [31:0] in_cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_max_value,
  output logic        out_bad_range,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_QRD = 4'd2, S_QWT = 4'd3,
                         S_OUT = 4'd4, S_BRD = 4'd5, S_BRD2 = 4'd6, S_BWR = 4'd7,
                         S_BNX = 4'd8, S_BG = 4'd9;

  logic [3:0]  st_r;
  logic [5:0]  rows_r, cols_r;
  logic [9:0]  clr_r;
  // build indices
  logic [2:0]  kr_r, kc_r;
  logic [4:0]  r_r, c_r;
  logic [31:0] a_r;
  // query
  logic [4:0]  qrs_r, qcs_r, qr2_r, qc2_r;
  logic [2:0]  qkr_r, qkc_r;
  logic [2:0]  qn_r;
  logic [31:0] acc_r;
  logic        bad_r;

  // grid memory
  logic        g_we;
  logic [9:0]  g_addr;
  logic [31:0] g_wd, g_rd;
  rmst_mem #(.Depth(1024), .Aw(10)) u_grid (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wd), .rdata(g_rd));

  // table memory: {kr,r,kc,c} = 3+5+3+5 bits
  logic        t_we;
  logic [15:0] t_addr;
  logic [31:0] t_wd, t_rd;
  rmst_mem #(.Depth(65536), .Aw(16)) u_tab (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));

  function automatic logic [15:0] ta(input logic [2:0] kr, input logic [4:0] r,
                                     input logic [2:0] kc, input logic [4:0] c);
    return {kr, r, kc, c};
  endfunction

  logic [5:0] rl, cl;
  logic       in_bad;
  assign rl = {1'b0, in_row_end} - {1'b0, in_row_start} + 6'd1;
  assign cl = {1'b0, in_col_end} - {1'b0, in_col_start} + 6'd1;
  assign in_bad = (in_row_start > in_row_end) || (in_col_start > in_col_end) ||
                  ({1'b0, in_row_end} >= rows_r) || ({1'b0, in_col_end} >= cols_r);

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_max_value = bad_r ? 32'd0 : acc_r;
  assign out_bad_range = bad_r;

  // entry span checks for the build walk
  logic [6:0] rspan, cspan;
  logic       ent_ok, kc_ok, kr_ok;
  assign rspan = 7'(r_r) + (7'd1 << kr_r);
  assign cspan = 7'(c_r) + (7'd1 << kc_r);
  assign ent_ok = (rspan <= 7'(rows_r)) && (cspan <= 7'(cols_r));
  assign kc_ok = (7'd1 << kc_r) <= 7'(cols_r);
  assign kr_ok = (7'd1 << kr_r) <= 7'(rows_r);

  logic [4:0] hr, hc;
  assign hr = (kr_r == 3'd0) ? 5'd0 : 5'(5'd1 << (kr_r - 3'd1));
  assign hc = (kc_r == 3'd0) ? 5'd0 : 5'(5'd1 << (kc_r - 3'd1));

  always_comb begin
    g_we = 1'b0; g_addr = {r_r, c_r}; g_wd = in_cell_value;
    t_we = 1'b0; t_addr = 16'd0; t_wd = 32'd0;
    unique case (st_r)
      S_CLR: begin
        g_we = 1'b1; g_addr = clr_r; g_wd = 32'd0;
      end
      S_IDLE: begin
        g_addr = {in_row_start, in_col_start};
        g_we = in_valid && in_req_type == rmst_pkg::REQ_WRITE;
      end
      S_QRD: begin
        unique case (qn_r[1:0])
          2'd0: t_addr = ta(qkr_r, qrs_r, qkc_r, qcs_r);
          2'd1: t_addr = ta(qkr_r, qrs_r, qkc_r, qc2_r);
          2'd2: t_addr = ta(qkr_r, qr2_r, qkc_r, qcs_r);
          default: t_addr = ta(qkr_r, qr2_r, qkc_r, qc2_r);
        endcase
      end
      S_BRD: begin
        // level 0 reads the grid; otherwise first half entry
        if (kr_r != 3'd0) t_addr = ta(kr_r - 3'd1, r_r, kc_r, c_r);
        else if (kc_r != 3'd0) t_addr = ta(3'd0, r_r, kc_r - 3'd1, c_r);
      end
      S_BRD2: begin
        if (kr_r != 3'd0) t_addr = ta(kr_r - 3'd1, r_r + hr, kc_r, c_r);
        else t_addr = ta(3'd0, r_r, kc_r - 3'd1, c_r + hc);
      end
      S_BWR: begin
        t_we = 1'b1; t_addr = ta(kr_r, r_r, kc_r, c_r);
        t_wd = (kr_r == 3'd0 && kc_r == 3'd0) ? g_rd : rmst_pkg::smax(a_r, t_rd);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= 10'd0; rows_r <= 6'd32; cols_r <= 6'd32;
      qn_r <= 3'd0; bad_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        logic [5:0] v;
        v = (cfg_data == 6'd0) ? 6'd1 : (cfg_data > 6'd32 ? 6'd32 : cfg_data);
        if (cfg_index == rmst_pkg::CFG_ROWS) rows_r <= v;
        else cols_r <= v;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 10'd1;
          if (clr_r == 10'd1023) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          if (in_req_type == rmst_pkg::REQ_QUERY) begin
            bad_r <= in_bad;
            qrs_r <= in_row_start; qcs_r <= in_col_start;
            qkr_r <= rmst_pkg::flog2(rl); qkc_r <= rmst_pkg::flog2(cl);
            qr2_r <= 5'(6'(in_row_start) + rl - (6'd1 << rmst_pkg::flog2(rl)));
            qc2_r <= 5'(6'(in_col_start) + cl - (6'd1 << rmst_pkg::flog2(cl)));
            qn_r <= 3'd0;
            st_r <= in_bad ? S_OUT : S_QRD;
          end else if (in_req_type == rmst_pkg::REQ_BUILD) begin
            kr_r <= 3'd0; kc_r <= 3'd0; r_r <= 5'd0; c_r <= 5'd0;
            st_r <= S_BG;
          end
        end
        S_QRD: begin
          // Reads issue for qn_r 0..3; each read's data returns in the next cycle.
          if (qn_r != 3'd0) acc_r <= (qn_r == 3'd1) ? t_rd : rmst_pkg::smax(acc_r, t_rd);
          qn_r <= qn_r + 3'd1;
          if (qn_r == 3'd3) st_r <= S_QWT;
        end
        S_QWT: begin
          acc_r <= rmst_pkg::smax(acc_r, t_rd);
          st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        S_BG: begin
          // Skip entries whose block leaves the grid in use; end once the row level no longer fits.
          if (!kr_ok) st_r <= S_IDLE;
          else if (!kc_ok || !ent_ok) st_r <= S_BNX;
          else st_r <= S_BRD;
        end
        S_BRD: st_r <= (kr_r == 3'd0 && kc_r == 3'd0) ? S_BWR : S_BRD2;
        S_BRD2: begin
          a_r <= t_rd; st_r <= S_BWR;
        end
        S_BWR: st_r <= S_BNX;
        S_BNX: begin
          // Order: kr outer, then r, kc, c; kr = 0 walks kc inside each row.
          st_r <= S_BG;
          if (kc_ok && c_r != 5'd31 && 6'(c_r) + 6'd1 < cols_r) c_r <= c_r + 5'd1;
          else begin
            c_r <= 5'd0;
            if (kc_ok && kc_r != 3'(rmst_pkg::Levels - 1)) kc_r <= kc_r + 3'd1;
            else begin
              kc_r <= 3'd0;
              if (r_r != 5'd31 && 6'(r_r) + 6'd1 < rows_r) r_r <= r_r + 5'd1;
              else begin
                r_r <= 5'd0;
                if (kr_r == 3'(rmst_pkg::Levels - 1)) st_r <= S_IDLE;
                else kr_r <= kr_r + 3'd1;
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_range |-> out_max_value == 32'd0) else $error("bad nonzero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

[design/rmst_mem.sv]
// Single-port synchronous memory with registered read data.
// Depends on nothing.
module rmst_mem #(
  parameter int Depth = 1024,
  parameter int Aw = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[tb/testbench.sv]
// Self-checking testbench for range_max_sparse_table_2d: cell writes, table builds and
// rectangle max queries against an in-bench predictor. Depends on rmst_pkg and the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  req;
    logic [4:0]  rs;
    logic [4:0]  cs;
    logic [4:0]  re;
    logic [4:0]  ce;
    logic [31:0] val;
  } grid_req_t;

  typedef struct packed {
    logic [31:0] max_value;
    logic        bad_range;
  } rect_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = '0;
  logic [4:0] in_row_start = '0;
  logic [4:0] in_col_start = '0;
  logic [4:0] in_row_end = '0;
  logic [4:0] in_col_end = '0;
  logic [31:0] in_cell_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_max_value;
  logic out_bad_range;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  range_max_sparse_table_2d uut (.*);

  always #6 clk = ~clk;

  // Predictor state: grid, block table and which table entries a build has written.
  logic [31:0] grid_model [0:rmst_pkg::MaxDim*rmst_pkg::MaxDim-1];
  logic [31:0] block_tab [0:rmst_pkg::Levels-1][0:rmst_pkg::MaxDim-1]
                         [0:rmst_pkg::Levels-1][0:rmst_pkg::MaxDim-1];
  bit          tab_built [0:rmst_pkg::Levels-1][0:rmst_pkg::MaxDim-1]
                         [0:rmst_pkg::Levels-1][0:rmst_pkg::MaxDim-1];
  int          rows_used = 32;
  int          cols_used = 32;

  grid_req_t    pending_reqs[$];
  rect_result_t expected_maxes[$];
  int  errors = 0;
  int  idle_in_pct = 0;
  int  idle_out_pct = 0;
  bit  long_hold = 1'b0;
  int  quiet_cycles = 0;

  function automatic int clamp_dim(input logic [5:0] v);
    if (v == 0) return 1;
    if (v > rmst_pkg::MaxDim) return rmst_pkg::MaxDim;
    return int'(v);
  endfunction

  function automatic int level_of(input int len);
    int k;
    k = 0;
    while ((len >> 1) != 0) begin
      len = len >> 1;
      k++;
    end
    if (k > rmst_pkg::Levels - 1) k = rmst_pkg::Levels - 1;
    return k;
  endfunction

  function automatic logic [31:0] signed_max(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic void rebuild_blocks();
    int half;
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        block_tab[0][r][0][c] = grid_model[r*rmst_pkg::MaxDim + c];
        tab_built[0][r][0][c] = 1'b1;
      end
      for (int kc = 1; kc < rmst_pkg::Levels && (1 << kc) <= cols_used; kc++) begin
        half = 1 << (kc - 1);
        for (int c = 0; c + (1 << kc) <= cols_used; c++) begin
          block_tab[0][r][kc][c] = signed_max(block_tab[0][r][kc-1][c],
                                              block_tab[0][r][kc-1][c+half]);
          tab_built[0][r][kc][c] = 1'b1;
        end
      end
    end
    for (int kr = 1; kr < rmst_pkg::Levels && (1 << kr) <= rows_used; kr++) begin
      half = 1 << (kr - 1);
      for (int r = 0; r + (1 << kr) <= rows_used; r++)
        for (int kc = 0; kc < rmst_pkg::Levels && (1 << kc) <= cols_used; kc++)
          for (int c = 0; c + (1 << kc) <= cols_used; c++) begin
            block_tab[kr][r][kc][c] = signed_max(block_tab[kr-1][r][kc][c],
                                                 block_tab[kr-1][r+half][kc][c]);
            tab_built[kr][r][kc][c] = 1'b1;
          end
    end
  endfunction

  // Returns 0 when the rectangle would read a table entry that was never built.
  function automatic bit rect_max(input grid_req_t q, output rect_result_t res);
    int kr, kc, r2, c2;
    res = '0;
    if (q.rs > q.re || q.cs > q.ce || q.re >= rows_used || q.ce >= cols_used) begin
      res.bad_range = 1'b1;
      return 1'b1;
    end
    kr = level_of(q.re - q.rs + 1);
    kc = level_of(q.ce - q.cs + 1);
    r2 = q.re + 1 - (1 << kr);
    c2 = q.ce + 1 - (1 << kc);
    if (!(tab_built[kr][q.rs][kc][q.cs] && tab_built[kr][q.rs][kc][c2] &&
          tab_built[kr][r2][kc][q.cs] && tab_built[kr][r2][kc][c2]))
      return 1'b0;
    res.max_value = signed_max(signed_max(block_tab[kr][q.rs][kc][q.cs],
                                          block_tab[kr][q.rs][kc][c2]),
                               signed_max(block_tab[kr][r2][kc][q.cs],
                                          block_tab[kr][r2][kc][c2]));
    return 1'b1;
  endfunction

  // Queues one request and its expected result, if any; refuses unbuilt reads.
  function automatic bit issue(input logic [1:0] req, input logic [4:0] rs,
                               input logic [4:0] cs, input logic [4:0] re,
                               input logic [4:0] ce, input logic [31:0] val);
    grid_req_t    q;
    rect_result_t res;
    q = '{req, rs, cs, re, ce, val};
    if (req == rmst_pkg::REQ_QUERY) begin
      if (!rect_max(q, res)) return 1'b0;
      expected_maxes.push_back(res);
    end else if (req == rmst_pkg::REQ_WRITE) begin
      grid_model[rs*rmst_pkg::MaxDim + cs] = val;
    end else if (req == rmst_pkg::REQ_BUILD) begin
      rebuild_blocks();
    end
    pending_reqs.push_back(q);
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic void random_query();
    logic [4:0] rs, cs, re, ce;
    repeat (20) begin
      if ($urandom_range(0, 99) < 15) begin
        rs = 5'($urandom()); cs = 5'($urandom()); re = 5'($urandom()); ce = 5'($urandom());
      end else begin
        rs = 5'($urandom_range(0, rows_used - 1));
        re = 5'($urandom_range(rs, rows_used - 1));
        cs = 5'($urandom_range(0, cols_used - 1));
        ce = 5'($urandom_range(cs, cols_used - 1));
      end
      if (issue(rmst_pkg::REQ_QUERY, rs, cs, re, ce, $urandom())) return;
    end
    void'(issue(rmst_pkg::REQ_QUERY, 5'd1, 5'd0, 5'd0, 5'd0, $urandom()));
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_maxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [5:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rmst_pkg::CFG_ROWS) rows_used = clamp_dim(data);
    else cols_used = clamp_dim(data);
  endtask

  // Driver: holds the payload until the transfer, then offers the next request.
  always @(posedge clk) begin : driver
    bit take, offer;
    take = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) void'(pending_reqs.pop_front());
      if (in_valid && !take) offer = 1'b1;
      else offer = pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_in_pct;
      if (offer) begin
        in_req_type <= pending_reqs[0].req;
        in_row_start <= pending_reqs[0].rs;
        in_col_start <= pending_reqs[0].cs;
        in_row_end <= pending_reqs[0].re;
        in_col_end <= pending_reqs[0].ce;
        in_cell_value <= pending_reqs[0].val;
      end
      in_valid <= offer;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    rect_result_t want;
    int  hold_left;
    bit  hold_done;
    if (out_valid && out_ready && rst_n) begin
      if (expected_maxes.size() == 0) begin
        $display("%0t: expected no result, actual max_value=%h bad_range=%b",
                 $realtime, out_max_value, out_bad_range);
        errors++;
      end else begin
        want = expected_maxes.pop_front();
        if (out_max_value !== want.max_value) begin
          $display("%0t: max_value expected %h actual %h",
                   $realtime, want.max_value, out_max_value);
          errors++;
        end
        if (out_bad_range !== want.bad_range) begin
          $display("%0t: bad_range expected %b actual %b",
                   $realtime, want.bad_range, out_bad_range);
          errors++;
        end
      end
    end
    if (long_hold && !hold_done) begin
      hold_left = 600;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && $urandom_range(0, 99) >= idle_out_pct;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [5:0] row_cfg [7];
    logic [5:0] col_cfg [7];
    int pick, n_items;
    row_cfg = '{6'd0, 6'd5, 6'd63, 6'd2, 6'd8, 6'd17, 6'd1};
    col_cfg = '{6'd63, 6'd3, 6'd0, 6'd2, 6'd16, 6'd31, 6'd7};
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner extremes, full and single-cell rectangles, reversed ones, stale read.
    idle_in_pct = 31;
    idle_out_pct = 76;
    void'(issue(rmst_pkg::REQ_WRITE, 5'd0, 5'd0, 5'd0, 5'd0, 32'h7fff_ffff));
    void'(issue(rmst_pkg::REQ_WRITE, 5'd31, 5'd31, 5'd0, 5'd0, 32'h8000_0000));
    void'(issue(rmst_pkg::REQ_WRITE, 5'd0, 5'd31, 5'd0, 5'd0, 32'hffff_ffff));
    void'(issue(rmst_pkg::REQ_WRITE, 5'd31, 5'd0, 5'd0, 5'd0, 32'h1234_5678));
    void'(issue(rmst_pkg::REQ_BUILD, 5'd0, 5'd0, 5'd0, 5'd0, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd0, 5'd0, 5'd31, 5'd31, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd31, 5'd31, 5'd31, 5'd31, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd0, 5'd31, 5'd0, 5'd31, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd31, 5'd0, 5'd31, 5'd31, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd1, 5'd1, 5'd30, 5'd30, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd0, 5'd1, 5'd2, 5'd30, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd5, 5'd0, 5'd4, 5'd31, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd0, 5'd9, 5'd31, 5'd8, 32'h0));
    void'(issue(REQ_UNUSED, 5'd3, 5'd3, 5'd9, 5'd9, 32'hdead_beef));
    void'(issue(rmst_pkg::REQ_WRITE, 5'd1, 5'd1, 5'd0, 5'd0, 32'h7fff_ffff));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd1, 5'd1, 5'd1, 5'd1, 32'h0));
    void'(issue(rmst_pkg::REQ_QUERY, 5'd1, 5'd0, 5'd0, 5'd0, 32'h0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 2) begin
        idle_in_pct = 31; idle_out_pct = 76;
      end else if (ph < 4) begin
        idle_in_pct = 76; idle_out_pct = 31;
      end else begin
        idle_in_pct = 0; idle_out_pct = 0;
      end
      write_reg(rmst_pkg::CFG_ROWS, row_cfg[ph]);
      write_reg(rmst_pkg::CFG_COLS, col_cfg[ph]);
      if (ph == 1) long_hold = 1'b1;
      n_items = 105;
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (i == n_items / 2) begin
          void'(issue(rmst_pkg::REQ_BUILD, 5'($urandom()), 5'($urandom()),
                      5'($urandom()), 5'($urandom()), $urandom()));
        end else if (pick < 40) begin
          if ($urandom_range(0, 9) < 7)
            void'(issue(rmst_pkg::REQ_WRITE, 5'($urandom_range(0, rows_used - 1)),
                        5'($urandom_range(0, cols_used - 1)), 5'($urandom()),
                        5'($urandom()), rand_value()));
          else
            void'(issue(rmst_pkg::REQ_WRITE, 5'($urandom()), 5'($urandom()),
                        5'($urandom()), 5'($urandom()), rand_value()));
        end else if (pick < 46) begin
          void'(issue(REQ_UNUSED, 5'($urandom()), 5'($urandom()), 5'($urandom()),
                      5'($urandom()), $urandom()));
        end else begin
          random_query();
        end
      end
      // A closing reversed query proves the block idle before the next register write.
      void'(issue(rmst_pkg::REQ_QUERY, 5'd2, 5'd0, 5'd1, 5'd0, $urandom()));
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
